// ===== rtl/range_minimum_query_macros.svh =====
// Assertion macros for the range minimum query block.
// Define ASSERT_OFF to drop every assertion from the build.
`ifndef RANGE_MINIMUM_QUERY_MACROS_SVH
`define RANGE_MINIMUM_QUERY_MACROS_SVH
`ifndef ASSERT_OFF
`define RMQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("range_minimum_query assertion failed");
`define RMQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("range_minimum_query assertion failed");
`else
`define RMQ_ASSERT_IMPL(label, clk, rst, ante, cons)
`define RMQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/rmq_pkg.sv =====
// Package for the range minimum query block: field widths, codes and states.
// Used by the channel interfaces and the range_minimum_query module.
package rmq_pkg;

  localparam int MAX_LEN_DEF    = 1024;
  localparam int BLOCK_SIZE_DEF = 9;
  localparam int OP_W           = 2;
  localparam int VAL_W          = 32;
  localparam int IDX_FIELD_W    = 10;

  localparam logic signed [VAL_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_APP,
    S_ARD,
    S_AWR,
    S_QDIV,
    S_QSET,
    S_QSCAN,
    S_QDRAIN,
    S_QT1,
    S_QTD,
    S_OUT
  } state_t;

endpackage

// ===== rtl/rmq_if.sv =====
// Channel interfaces of the range minimum query block: request and response words.
// Depends on rmq_pkg for the field widths.
interface rmq_req_if;
  logic                                   valid;
  logic                                   ready;
  logic [rmq_pkg::OP_W-1:0]               op;
  logic signed [rmq_pkg::VAL_W-1:0]       value;
  logic [rmq_pkg::IDX_FIELD_W-1:0]        left;
  logic [rmq_pkg::IDX_FIELD_W-1:0]        right;
  modport source (output valid, op, value, left, right, input ready);
  modport sink   (input valid, op, value, left, right, output ready);
endinterface

interface rmq_rsp_if;
  logic                             valid;
  logic                             ready;
  logic signed [rmq_pkg::VAL_W-1:0] min_value;
  logic                             range_error;
  modport source (output valid, min_value, range_error, input ready);
  modport sink   (input valid, min_value, range_error, output ready);
endinterface

// ===== rtl/range_minimum_query.sv =====
// Range minimum query over a sequence of signed words kept in an element RAM and a
// RAM holding a sparse table of block minima. Clear empties the sequence. Append stores
// the element and then updates each higher table level the new block touches (at most 6
// at default size). A query scans the elements of the two end blocks one at a time
// through the single read port of the element RAM (up to 2*BlockSize elements), plus
// two table lookups when whole blocks lie between them; an invalid range skips the scan
// and returns an error. Reset empties the sequence at once; no clearing pass runs.
// Depends on rmq_pkg, rmq_if, rmq_ram and the macro header.
`include "range_minimum_query_macros.svh"

module range_minimum_query #(
  parameter int MaxLen    = rmq_pkg::MAX_LEN_DEF,
  parameter int BlockSize = rmq_pkg::BLOCK_SIZE_DEF
) (
  input logic    clk,
  input logic    rst,
  rmq_req_if.sink   req,
  rmq_rsp_if.source rsp
);
  import rmq_pkg::*;

  localparam int AW    = $clog2(MaxLen);
  localparam int CW    = AW + 1;
  localparam int QW    = ((AW > IDX_FIELD_W) ? AW : IDX_FIELD_W) + 1;
  localparam int NB    = (MaxLen + BlockSize - 1) / BlockSize;
  localparam int BW    = (NB > 1) ? $clog2(NB) : 1;
  localparam int LVLN  = $clog2(NB + 1);
  localparam int LW    = $clog2(LVLN + 1);
  localparam int SW    = LVLN + 1;
  localparam int TDEP  = LVLN * NB;
  localparam int TAW   = $clog2(TDEP);
  localparam int OW    = (BlockSize > 2) ? $clog2(BlockSize) : 1;
  localparam int DS    = QW + 1;
  localparam int RECIP = (1 << DS) / BlockSize;

  // Block number of an index: multiply by a reciprocal, then one correction step.
  function automatic logic [QW-1:0] blk_of(input logic [QW-1:0] x);
    logic [QW+DS-1:0] prod;
    logic [QW-1:0]    q;
    logic [QW-1:0]    rem;
    prod = (QW+DS)'(x) * (QW+DS)'(RECIP);
    q    = QW'(prod >> DS);
    rem  = x - QW'(q * QW'(BlockSize));
    if (rem >= QW'(BlockSize)) begin
      q = q + QW'(1);
    end
    return q;
  endfunction

  state_t state, state_next;
  logic [CW-1:0]           count, count_next;
  logic [BW-1:0]           app_blk, app_blk_next, ublk, ublk_next, jblk, jblk_next;
  logic [OW-1:0]           app_off, app_off_next;
  logic signed [VAL_W-1:0] bmin, bmin_next, cur, cur_next, val_reg, val_reg_next;
  logic signed [VAL_W-1:0] ans, ans_next, ans_fold;
  logic [LW-1:0]           lvl, lvl_next;
  logic [QW-1:0]           l_reg, l_reg_next, r_reg, r_reg_next;
  logic [QW-1:0]           bi, bi_next, bj, bj_next, ptr, ptr_next, seg_end, seg_end_next;
  logic                    seg2, seg2_next, err, err_next;
  logic                    rv, rv_next, tv, tv_next;
  logic [TAW-1:0]          ty_addr, ty_addr_next;
  logic                    out_valid, out_valid_next, out_err, out_err_next;
  logic signed [VAL_W-1:0] out_min, out_min_next;

  logic                    e_we, t_we;
  logic [AW-1:0]           e_waddr, e_raddr;
  logic [TAW-1:0]          t_waddr, t_raddr;
  logic signed [VAL_W-1:0] e_wdata, t_wdata, e_rdata, t_rdata;

  rmq_ram #(.Width(VAL_W), .Depth(MaxLen)) u_elem (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  rmq_ram #(.Width(VAL_W), .Depth(TDEP)) u_table (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.min_value   = out_min;
  assign rsp.range_error = out_err;

  // State register and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      app_blk   <= '0;
      app_off   <= '0;
      rv        <= 1'b0;
      tv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      app_blk   <= app_blk_next;
      app_off   <= app_off_next;
      rv        <= rv_next;
      tv        <= tv_next;
      out_valid <= out_valid_next;
    end
    ublk    <= ublk_next;
    jblk    <= jblk_next;
    bmin    <= bmin_next;
    cur     <= cur_next;
    val_reg <= val_reg_next;
    ans     <= ans_next;
    lvl     <= lvl_next;
    l_reg   <= l_reg_next;
    r_reg   <= r_reg_next;
    bi      <= bi_next;
    bj      <= bj_next;
    ptr     <= ptr_next;
    seg_end <= seg_end_next;
    seg2    <= seg2_next;
    err     <= err_next;
    ty_addr <= ty_addr_next;
    out_err <= out_err_next;
    out_min <= out_min_next;
  end

  // Next state, memory accesses and outputs.
  always_comb begin
    logic [QW-1:0]           lq, rq, cnt;
    logic signed [VAL_W-1:0] newmin, m;
    logic [SW-1:0]           span;
    logic [LW-1:0]           k;
    logic [BW-1:0]           j;

    state_next     = state;
    count_next     = count;
    app_blk_next   = app_blk;
    app_off_next   = app_off;
    ublk_next      = ublk;
    jblk_next      = jblk;
    bmin_next      = bmin;
    cur_next       = cur;
    val_reg_next   = val_reg;
    lvl_next       = lvl;
    l_reg_next     = l_reg;
    r_reg_next     = r_reg;
    bi_next        = bi;
    bj_next        = bj;
    ptr_next       = ptr;
    seg_end_next   = seg_end;
    seg2_next      = seg2;
    err_next       = err;
    ty_addr_next   = ty_addr;
    rv_next        = 1'b0;
    tv_next        = 1'b0;
    out_valid_next = out_valid;
    out_err_next   = out_err;
    out_min_next   = out_min;
    e_we           = 1'b0;
    e_waddr        = count[AW-1:0];
    e_wdata        = val_reg;
    e_raddr        = ptr[AW-1:0];
    t_we           = 1'b0;
    t_waddr        = '0;
    t_wdata        = cur;
    t_raddr        = ty_addr;
    lq             = QW'(req.left);
    rq             = QW'(req.right);
    cnt            = '0;
    newmin         = val_reg;
    m              = cur;
    span           = '0;
    k              = '0;
    j              = '0;

    // Fold read data from the previous cycle into the running minimum.
    ans_fold = ans;
    if (rv && (e_rdata < ans_fold)) begin
      ans_fold = e_rdata;
    end
    if (tv && (t_rdata < ans_fold)) begin
      ans_fold = t_rdata;
    end
    ans_next = ans_fold;

    // The response word leaves when taken.
    if (out_valid && rsp.ready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          priority case (op_t'(req.op))
            OP_CLEAR: begin
              count_next   = '0;
              app_blk_next = '0;
              app_off_next = '0;
            end
            OP_APPEND: begin
              if (count != CW'(MaxLen)) begin
                val_reg_next = req.value;
                state_next   = S_APP;
              end
            end
            OP_QUERY: begin
              l_reg_next = lq;
              r_reg_next = rq;
              if ((rq < lq) || (rq >= QW'(count))) begin
                err_next   = 1'b1;
                ans_next   = '0;
                state_next = S_OUT;
              end else begin
                err_next   = 1'b0;
                state_next = S_QDIV;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Store the element and refresh the level-zero entry of its block.
      S_APP: begin
        if ((app_off == '0) || (val_reg < bmin)) begin
          newmin = val_reg;
        end else begin
          newmin = bmin;
        end
        e_we      = 1'b1;
        t_we      = 1'b1;
        t_waddr   = TAW'(app_blk);
        t_wdata   = newmin;
        bmin_next = newmin;
        cur_next  = newmin;
        ublk_next = app_blk;
        lvl_next  = LW'(1);
        count_next = count + CW'(1);
        if (app_off == OW'(BlockSize - 1)) begin
          app_off_next = '0;
          app_blk_next = app_blk + BW'(1);
        end else begin
          app_off_next = app_off + OW'(1);
        end
        state_next = S_ARD;
      end

      // Read the lower half of the next level's entry that ends at this block.
      S_ARD: begin
        span = SW'(1) << lvl;
        if ((lvl == LW'(LVLN)) || (span > (SW'(ublk) + SW'(1)))) begin
          state_next = S_IDLE;
        end else begin
          j          = BW'(SW'(ublk) + SW'(1) - span);
          jblk_next  = j;
          t_raddr    = TAW'(TAW'(lvl - LW'(1)) * TAW'(NB)) + TAW'(j);
          state_next = S_AWR;
        end
      end

      // Combine with the running minimum and write the entry back.
      S_AWR: begin
        if (t_rdata < cur) begin
          m = t_rdata;
        end
        t_we       = 1'b1;
        t_waddr    = TAW'(TAW'(lvl) * TAW'(NB)) + TAW'(jblk);
        t_wdata    = m;
        cur_next   = m;
        lvl_next   = lvl + LW'(1);
        state_next = S_ARD;
      end

      S_QDIV: begin
        bi_next    = blk_of(l_reg);
        bj_next    = blk_of(r_reg);
        state_next = S_QSET;
      end

      // Set up the scan of the first end block.
      S_QSET: begin
        ptr_next = l_reg;
        ans_next = INT_MAX;
        if (bi == bj) begin
          seg_end_next = r_reg;
          seg2_next    = 1'b0;
        end else begin
          seg_end_next = QW'((bi + QW'(1)) * QW'(BlockSize)) - QW'(1);
          seg2_next    = 1'b1;
        end
        state_next = S_QSCAN;
      end

      // One element read per cycle over the end blocks.
      S_QSCAN: begin
        rv_next = 1'b1;
        if (ptr == seg_end) begin
          if (seg2) begin
            ptr_next     = QW'(bj * QW'(BlockSize));
            seg_end_next = r_reg;
            seg2_next    = 1'b0;
          end else begin
            state_next = S_QDRAIN;
          end
        end else begin
          ptr_next = ptr + QW'(1);
        end
      end

      // Whole blocks in between take two overlapping table lookups.
      S_QDRAIN: begin
        if ((bj - bi) > QW'(1)) begin
          cnt = bj - bi - QW'(1);
          for (int i = 0; i < QW; i++) begin
            if (cnt[i]) begin
              k = LW'(i);
            end
          end
          t_raddr      = TAW'(TAW'(k) * TAW'(NB)) + TAW'(bi + QW'(1));
          ty_addr_next = TAW'(TAW'(k) * TAW'(NB)) + TAW'(bj - (QW'(1) << k));
          tv_next      = 1'b1;
          state_next   = S_QT1;
        end else begin
          state_next = S_OUT;
        end
      end

      S_QT1: begin
        t_raddr    = ty_addr;
        tv_next    = 1'b1;
        state_next = S_QTD;
      end

      S_QTD: begin
        state_next = S_OUT;
      end

      // Hand the result to the output register once it is free.
      S_OUT: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next = 1'b1;
          out_err_next   = err;
          out_min_next   = err ? '0 : ans;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Checks on the block's own bookkeeping.
  `RMQ_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= CW'(MaxLen))
  `RMQ_ASSERT_IMPL(a_err_zero, clk, rst, rsp.valid && rsp.range_error, rsp.min_value == '0)
  `RMQ_ASSERT_NEXT(a_append_grows, clk, rst, state == S_APP, count == $past(count) + CW'(1))

endmodule

// ===== rtl/rmq_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; no package needed.
module rmq_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
